// ===== sv/table_linear_interpolator_unit_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tli_pkg.sv =====
package tli_pkg;

    localparam int TABLE_DEPTH   = 32;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int LEN_W         = $clog2(TABLE_DEPTH + 1);
    localparam int SIDX_W        = LEN_W + 1;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int DIV_RADIX_W   = 2;
    localparam int DIV_STEPS     = PROD_W / DIV_RADIX_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic REG_KEY_COLUMN   = 1'b0;
    localparam logic REG_TABLE_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END_FIRST,
        S_END_LAST,
        S_CHECK,
        S_EVAL,
        S_FETCH_HIT,
        S_FETCH_NEIGHBOR,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } wr_req_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== sv/tli_ram.sv =====
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tli_div.sv =====
`include "table_linear_interpolator_unit_defines.svh"

module tli_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tli_pkg::div_req_t               req,
    output logic                            done,
    output logic [tli_pkg::DATA_W-1:0]      quot
);

    tli_pkg::div_state_t              state_reg, state_next;
    logic [tli_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tli_pkg::DATA_W-1:0]       rem_reg, rem_next;
    logic [tli_pkg::PROD_W-1:0]       dvd_reg, dvd_next;
    logic [tli_pkg::DATA_W-1:0]       dvs_reg, dvs_next;
    logic                             neg_reg, neg_next;
    logic                             zero_reg, zero_next;
    logic [tli_pkg::DATA_W-1:0]       step_rem;
    logic [tli_pkg::PROD_W-1:0]       step_dvd;
    logic [tli_pkg::DATA_W:0]         trial;

    // Restoring division, two quotient bits per cycle. The quotient bits
    // shift into the low end of the dividend register.
    always_comb
    begin
        step_rem = rem_reg;
        step_dvd = dvd_reg;
        trial    = '0;
        for (int k = 0; k < tli_pkg::DIV_RADIX_W; k++)
        begin
            trial    = {step_rem, step_dvd[tli_pkg::PROD_W-1]};
            step_dvd = {step_dvd[tli_pkg::PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                step_dvd[0] = 1'b1;
            end
            step_rem = trial[tli_pkg::DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        done       = 1'b0;
        case (state_reg)
            tli_pkg::DIV_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = '0;
                    dvd_next   = req.dividend[tli_pkg::PROD_W-1] ? -req.dividend
                                                                 : req.dividend;
                    dvs_next   = req.divisor[tli_pkg::DATA_W-1] ? -req.divisor
                                                                : req.divisor;
                    neg_next   = req.dividend[tli_pkg::PROD_W-1]
                               ^ req.divisor[tli_pkg::DATA_W-1];
                    zero_next  = (req.divisor == '0);
                    cnt_next   = '0;
                    state_next = tli_pkg::DIV_RUN;
                end
            end
            tli_pkg::DIV_RUN:
            begin
                rem_next = step_rem;
                dvd_next = step_dvd;
                cnt_next = cnt_reg + tli_pkg::DIV_CNT_W'(1);
                if (cnt_reg == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1))
                begin
                    state_next = tli_pkg::DIV_DONE;
                end
            end
            tli_pkg::DIV_DONE:
            begin
                done       = 1'b1;
                state_next = tli_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = tli_pkg::DIV_IDLE;
            end
        endcase
    end

    assign quot = zero_reg ? '0
                : (neg_reg ? -dvd_reg[tli_pkg::DATA_W-1:0] : dvd_reg[tli_pkg::DATA_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tli_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    `TLI_ASSERT_IMP(a_div_start_idle, clk, rst_n, req.start, state_reg == tli_pkg::DIV_IDLE, "Divider started while busy.")

endmodule

// ===== sv/tli_seq.sv =====
`include "table_linear_interpolator_unit_defines.svh"

module tli_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [4:0]                           entry_index,
    input  logic signed [31:0]                   entry_first,
    input  logic signed [31:0]                   entry_second,
    input  logic signed [31:0]                   lookup_ref,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   interp_value,
    input  logic                                 key_column,
    input  logic [5:0]                           table_length,
    output tli_pkg::wr_req_t                     wr_req,
    output tli_pkg::rd_req_t                     rd_req,
    input  logic [tli_pkg::DATA_W-1:0]           rd_first,
    input  logic [tli_pkg::DATA_W-1:0]           rd_second
);

    tli_pkg::seq_state_t                    state_reg, state_next;
    logic [tli_pkg::LEN_W-1:0]              len_reg, len_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [tli_pkg::DATA_W-1:0]      value_reg, value_next;
    logic signed [tli_pkg::DATA_W-1:0]      ref_reg, ref_next;
    logic signed [tli_pkg::DATA_W-1:0]      key0_reg, key0_next;
    logic                                   asc_reg, asc_next;
    logic signed [tli_pkg::SIDX_W-1:0]      lo_reg, lo_next;
    logic signed [tli_pkg::SIDX_W-1:0]      hi_reg, hi_next;
    logic signed [tli_pkg::SIDX_W-1:0]      idx_reg, idx_next;
    logic                                   clamp_reg, clamp_next;
    logic signed [tli_pkg::DATA_W-1:0]      keyi_reg, keyi_next;
    logic signed [tli_pkg::DATA_W-1:0]      outi_reg, outi_next;
    logic signed [tli_pkg::DATA_W-1:0]      numa_reg, numa_next;
    logic signed [tli_pkg::DATA_W-1:0]      numb_reg, numb_next;
    logic signed [tli_pkg::DATA_W-1:0]      den_reg, den_next;
    logic signed [tli_pkg::DATA_W-1:0]      base_reg, base_next;
    logic signed [tli_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic signed [tli_pkg::DATA_W-1:0]      res_reg, res_next;

    logic signed [tli_pkg::DATA_W-1:0]      key_data;
    logic signed [tli_pkg::DATA_W-1:0]      out_data;
    logic [tli_pkg::LEN_W-1:0]              len_clamp;
    logic signed [tli_pkg::SIDX_W-1:0]      len_s;
    logic signed [tli_pkg::SIDX_W-1:0]      half;
    logic signed [tli_pkg::SIDX_W-1:0]      mid;
    logic signed [tli_pkg::SIDX_W-1:0]      found;
    logic                                   out_load;
    tli_pkg::div_req_t                      div_req;
    logic                                   div_done;
    logic [tli_pkg::DATA_W-1:0]             div_quot;

    tli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign key_data = key_column ? rd_second : rd_first;
    assign out_data = key_column ? rd_first : rd_second;

    assign len_clamp = (table_length == '0) ? tli_pkg::LEN_W'(1)
                     : ((32'(table_length) > tli_pkg::TABLE_DEPTH)
                        ? tli_pkg::LEN_W'(tli_pkg::TABLE_DEPTH) : table_length);
    assign len_s = $signed({1'b0, len_reg});
    assign half  = (hi_reg - lo_reg) >>> 1;
    assign mid   = asc_reg ? (lo_reg + half) : (hi_reg - half);
    assign found = asc_reg ? lo_reg : hi_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ref_next   = ref_reg;
        key0_next  = key0_reg;
        asc_next   = asc_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        clamp_next = clamp_reg;
        keyi_next  = keyi_reg;
        outi_next  = outi_reg;
        numa_next  = numa_reg;
        numb_next  = numb_reg;
        den_next   = den_reg;
        base_next  = base_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        rd_req     = '0;
        div_req    = '0;
        wr_req.en     = 1'b0;
        wr_req.addr   = tli_pkg::IDX_W'(entry_index);
        wr_req.first  = entry_first;
        wr_req.second = entry_second;
        case (state_reg)
            tli_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == tli_pkg::KIND_WRITE)
                    begin
                        wr_req.en = (32'(entry_index) < tli_pkg::TABLE_DEPTH);
                    end
                    else
                    begin
                        ref_next    = lookup_ref;
                        len_next    = len_clamp;
                        rd_req.en   = 1'b1;
                        rd_req.addr = '0;
                        state_next  = tli_pkg::S_END_FIRST;
                    end
                end
            end
            tli_pkg::S_END_FIRST:
            begin
                key0_next   = key_data;
                rd_req.en   = 1'b1;
                rd_req.addr = tli_pkg::IDX_W'(len_reg - tli_pkg::LEN_W'(1));
                state_next  = tli_pkg::S_END_LAST;
            end
            tli_pkg::S_END_LAST:
            begin
                asc_next = (key0_reg < key_data);
                if (key0_reg < key_data)
                begin
                    lo_next = '0;
                    hi_next = len_s;
                end
                else
                begin
                    lo_next = -tli_pkg::SIDX_W'(1);
                    hi_next = len_s - tli_pkg::SIDX_W'(1);
                end
                state_next = tli_pkg::S_CHECK;
            end
            tli_pkg::S_CHECK:
            begin
                rd_req.en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    rd_req.addr = tli_pkg::IDX_W'(mid);
                    idx_next    = mid;
                    state_next  = tli_pkg::S_EVAL;
                end
                else
                begin
                    idx_next = found;
                    if (asc_reg && (found >= len_s))
                    begin
                        clamp_next  = 1'b1;
                        rd_req.addr = tli_pkg::IDX_W'(len_reg - tli_pkg::LEN_W'(1));
                    end
                    else if (!asc_reg && (found < 0))
                    begin
                        clamp_next  = 1'b1;
                        rd_req.addr = '0;
                    end
                    else
                    begin
                        clamp_next  = 1'b0;
                        rd_req.addr = tli_pkg::IDX_W'(found);
                    end
                    state_next = tli_pkg::S_FETCH_HIT;
                end
            end
            tli_pkg::S_EVAL:
            begin
                if (asc_reg)
                begin
                    if (key_data < ref_reg)
                    begin
                        lo_next = idx_reg + tli_pkg::SIDX_W'(1);
                    end
                    else
                    begin
                        hi_next = idx_reg;
                    end
                end
                else
                begin
                    if (ref_reg > key_data)
                    begin
                        hi_next = idx_reg - tli_pkg::SIDX_W'(1);
                    end
                    else
                    begin
                        lo_next = idx_reg;
                    end
                end
                state_next = tli_pkg::S_CHECK;
            end
            tli_pkg::S_FETCH_HIT:
            begin
                keyi_next = key_data;
                outi_next = out_data;
                if (clamp_reg || (key_data == ref_reg)
                    || (asc_reg && (idx_reg == '0))
                    || (!asc_reg && (idx_reg == len_s - tli_pkg::SIDX_W'(1))))
                begin
                    res_next   = out_data;
                    state_next = tli_pkg::S_OUT;
                end
                else
                begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = asc_reg ? tli_pkg::IDX_W'(idx_reg - tli_pkg::SIDX_W'(1))
                                          : tli_pkg::IDX_W'(idx_reg + tli_pkg::SIDX_W'(1));
                    state_next  = tli_pkg::S_FETCH_NEIGHBOR;
                end
            end
            tli_pkg::S_FETCH_NEIGHBOR:
            begin
                numa_next  = ref_reg - key_data;
                numb_next  = outi_reg - out_data;
                den_next   = keyi_reg - key_data;
                base_next  = out_data;
                state_next = tli_pkg::S_MUL;
            end
            tli_pkg::S_MUL:
            begin
                prod_next  = tli_pkg::PROD_W'(numa_reg) * tli_pkg::PROD_W'(numb_reg);
                state_next = tli_pkg::S_DIV_START;
            end
            tli_pkg::S_DIV_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = den_reg;
                state_next       = tli_pkg::S_DIV_WAIT;
            end
            tli_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    res_next   = base_reg + $signed(div_quot);
                    state_next = tli_pkg::S_OUT;
                end
            end
            tli_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = tli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tli_pkg::S_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        value_next     = out_load ? res_reg : value_reg;
    end

    assign out_valid    = out_valid_reg;
    assign interp_value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tli_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= tli_pkg::LEN_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ref_reg   <= ref_next;
        key0_reg  <= key0_next;
        asc_reg   <= asc_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        clamp_reg <= clamp_next;
        keyi_reg  <= keyi_next;
        outi_reg  <= outi_next;
        numa_reg  <= numa_next;
        numb_reg  <= numb_next;
        den_reg   <= den_next;
        base_reg  <= base_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
    end

    `TLI_ASSERT_IMP(a_read_in_table, clk, rst_n, rd_req.en && (state_reg != tli_pkg::S_IDLE), rd_req.addr < len_reg, "Table read beyond the entries in use.")
    `TLI_ASSERT_IMP(a_search_window, clk, rst_n, state_reg == tli_pkg::S_CHECK, lo_reg <= hi_reg, "Search window inverted.")
    `TLI_ASSERT_IMP(a_div_done_wait, clk, rst_n, div_done, state_reg == tli_pkg::S_DIV_WAIT, "Divider finished outside the wait state.")
    `TLI_ASSERT_IMP(a_out_from_seq, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == tli_pkg::S_OUT, "Result word appeared without a finished lookup.")

endmodule

// ===== sv/table_linear_interpolator_unit.sv =====
// Piecewise linear table interpolator.
// Input words arrive on in_valid/in_ready. A word with kind 0 writes the pair
// entry_first/entry_second into entry entry_index. A word with kind 1 looks up
// lookup_ref in the key column and returns one result word on out_valid/out_ready
// carrying interp_value. The table lives in two synchronous memories read at one
// entry per search step, with registered read data. A lookup reads both end
// entries, runs a binary search of one to six steps, each a read in S_CHECK and a
// compare in S_EVAL, and reads the bracketing pair. Exact hits and clamped
// references return the entry found. Interpolated results add a multiply state
// and a 64 by 32 bit divider that retires two quotient bits per cycle.
// One word is processed at a time; in_ready is high only while the block is idle.
// A finished result sits in an output register, so the next word can be taken
// while it waits. If the receiver stalls, a second result waits until the first
// is taken. Reset clears the control state, sets key_column to 0, table_length to
// 1; table entries hold no value until written. Configuration registers must be
// written over the APB port while the block is idle, which it does not enforce.
module table_linear_interpolator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [4:0]         entry_index,
    input  logic signed [31:0] entry_first,
    input  logic signed [31:0] entry_second,
    input  logic signed [31:0] lookup_ref,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] interp_value
);

    logic                              key_column_reg;
    logic                              key_column_next;
    logic [5:0]                        table_length_reg;
    logic [5:0]                        table_length_next;
    logic                              cfg_write;
    tli_pkg::wr_req_t                  wr_req;
    tli_pkg::rd_req_t                  rd_req;
    logic [tli_pkg::DATA_W-1:0]        rd_first;
    logic [tli_pkg::DATA_W-1:0]        rd_second;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        key_column_next   = key_column_reg;
        table_length_next = table_length_reg;
        prdata            = '0;
        case (paddr[2])
            tli_pkg::REG_KEY_COLUMN:
            begin
                prdata = 32'(key_column_reg);
                if (cfg_write)
                begin
                    key_column_next = pwdata[0];
                end
            end
            tli_pkg::REG_TABLE_LENGTH:
            begin
                prdata = 32'(table_length_reg);
                if (cfg_write)
                begin
                    table_length_next = pwdata[5:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_column_reg   <= 1'b0;
            table_length_reg <= 6'd1;
        end
        else
        begin
            key_column_reg   <= key_column_next;
            table_length_reg <= table_length_next;
        end
    end

    tli_ram #(
        .WIDTH (tli_pkg::DATA_W),
        .DEPTH (tli_pkg::TABLE_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (wr_req.en),
        .waddr (wr_req.addr),
        .wdata (wr_req.first),
        .re    (rd_req.en),
        .raddr (rd_req.addr),
        .rdata (rd_first)
    );

    tli_ram #(
        .WIDTH (tli_pkg::DATA_W),
        .DEPTH (tli_pkg::TABLE_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (wr_req.en),
        .waddr (wr_req.addr),
        .wdata (wr_req.second),
        .re    (rd_req.en),
        .raddr (rd_req.addr),
        .rdata (rd_second)
    );

    tli_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .entry_index  (entry_index),
        .entry_first  (entry_first),
        .entry_second (entry_second),
        .lookup_ref   (lookup_ref),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interp_value (interp_value),
        .key_column   (key_column_reg),
        .table_length (table_length_reg),
        .wr_req       (wr_req),
        .rd_req       (rd_req),
        .rd_first     (rd_first),
        .rd_second    (rd_second)
    );

endmodule
